// ===== rtl/hkv_pkg.sv =====
// ----------------------------------------------------------------------------
// hkv_pkg
// Shared widths, operation and status codes, and types for the hashed
// key-value table.
// ----------------------------------------------------------------------------
package hkv_pkg;

    localparam int KEY_W   = 31;
    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    localparam int DEFAULT_BUCKETS = 16;
    localparam int DEFAULT_WAYS    = 4;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam logic signed [VALUE_W-1:0] VAL_MISS = -32'sd1;
    localparam logic signed [VALUE_W-1:0] VAL_ACK  = 32'sd1;

    typedef struct packed {
        logic found;
        logic have_free;
    } way_hit_t;

endpackage

// ===== rtl/hkv_bucket_map.sv =====
// ----------------------------------------------------------------------------
// hkv_bucket_map
// Key to bucket mapping (key mod BUCKETS) by reciprocal multiply, registered
// quotient estimate, then one correcting compare and subtract.
// ----------------------------------------------------------------------------
module hkv_bucket_map
    import hkv_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS,
    parameter int BW      = 4
)
(
    input  logic             clk,
    input  logic             load,
    input  logic [KEY_W-1:0] key_in,
    output logic [KEY_W-1:0] key_out,
    output logic [BW-1:0]    bucket
);

    localparam logic [31:0]      RECIP = 32'((64'd1 << 31) / BUCKETS);
    localparam logic [KEY_W-1:0] DIV   = KEY_W'(BUCKETS);

    logic [62:0]      prod;
    logic [KEY_W-1:0] quot_next;
    logic [KEY_W-1:0] quot_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] qb;
    logic [KEY_W-1:0] rem;
    logic [KEY_W-1:0] rem_fix;

    assign prod      = 63'(key_in) * 63'(RECIP);
    assign quot_next = prod[61:31];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg <= quot_next;
            key_reg  <= key_in;
        end
    end

    // estimate is low by at most one, so the remainder stays below 2*BUCKETS
    assign qb      = KEY_W'(quot_reg * DIV);
    assign rem     = key_reg - qb;
    assign rem_fix = (rem >= DIV) ? rem - DIV : rem;
    assign bucket  = rem_fix[BW-1:0];
    assign key_out = key_reg;

endmodule

// ===== rtl/hkv_way_match.sv =====
// ----------------------------------------------------------------------------
// hkv_way_match
// Compares a key against all ways of one bucket row; gives the lowest
// matching valid way and the lowest free way.
// ----------------------------------------------------------------------------
module hkv_way_match
    import hkv_pkg::*;
#(
    parameter int WAYS = DEFAULT_WAYS,
    parameter int WW   = 2
)
(
    input  logic [KEY_W-1:0]            key,
    input  logic [WAYS-1:0][KEY_W-1:0]  row_keys,
    input  logic [WAYS-1:0]             row_valid,
    output way_hit_t                    info,
    output logic [WW-1:0]               match_way,
    output logic [WW-1:0]               free_way
);

    always_comb
    begin
        info      = '0;
        match_way = '0;
        free_way  = '0;
        // descending scan so the lowest way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_valid[w] && (row_keys[w] == key))
            begin
                info.found = 1'b1;
                match_way  = WW'(w);
            end
            if (!row_valid[w])
            begin
                info.have_free = 1'b1;
                free_way       = WW'(w);
            end
        end
    end

endmodule

// ===== rtl/hashed_key_value_table_core.sv =====
// ----------------------------------------------------------------------------
// hashed_key_value_table_core
// Set-associative key-value table with insert, read and delete.
// ----------------------------------------------------------------------------
// A command is taken on any cycle with start high (busy is never raised), and
// one word comes back per command on done, in command order; sustained rate
// is one command per cycle. The bucket stage forms the bucket (key mod
// BUCKETS) by a reciprocal multiply, the row read stage reads the bucket row
// from the row memory, and the compare stage compares all ways and writes the
// row back, with the row just written bypassed to a following command on the
// same bucket. The receiver cannot stall: done and its word are present for
// one cycle only. Valid bits are cleared by reset, so no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module hashed_key_value_table_core
    import hkv_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS,
    parameter int WAYS    = DEFAULT_WAYS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           operation,
    input  logic [KEY_W-1:0]          key,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      done,
    output logic signed [VALUE_W-1:0] result_value,
    output logic                      hit,
    output logic [STAT_W-1:0]         status
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [WAYS-1:0][KEY_W-1:0]   key_row_t;
    typedef logic [WAYS-1:0][VALUE_W-1:0] val_row_t;

    logic                      accept;

    logic                      s1_vld_reg;
    logic [OP_W-1:0]           s1_op_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic [KEY_W-1:0]          s1_key;
    logic [BW-1:0]             s1_bucket;

    logic                      s2_vld_reg;
    logic [OP_W-1:0]           s2_op_reg;
    logic [KEY_W-1:0]          s2_key_reg;
    logic signed [VALUE_W-1:0] s2_value_reg;
    logic [BW-1:0]             s2_bucket_reg;

    key_row_t                  key_mem [BUCKETS];
    val_row_t                  val_mem [BUCKETS];
    key_row_t                  row_keys_reg;
    val_row_t                  row_vals_reg;

    logic [BUCKETS-1:0][WAYS-1:0] valid_reg;
    logic [WAYS-1:0]           valid_row;
    logic [WAYS-1:0]           valid_row_next;

    way_hit_t                  way_info;
    logic [WW-1:0]             match_way;
    logic [WW-1:0]             free_way;

    logic                      row_wr_en;
    logic                      fwd;
    key_row_t                  wr_keys;
    val_row_t                  wr_vals;

    logic signed [VALUE_W-1:0] res_value;
    logic                      res_hit;
    logic [STAT_W-1:0]         res_status;

    logic                      done_reg;
    logic signed [VALUE_W-1:0] result_value_reg;
    logic                      hit_reg;
    logic [STAT_W-1:0]         status_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: bucket index

    hkv_bucket_map #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_bucket_map (
        .clk     (clk),
        .load    (accept),
        .key_in  (key),
        .key_out (s1_key),
        .bucket  (s1_bucket)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= operation;
            s1_value_reg <= value;
        end
        if (s1_vld_reg)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_key_reg    <= s1_key;
            s2_value_reg  <= s1_value_reg;
            s2_bucket_reg <= s1_bucket;
        end
    end

    // stage 2: row read, bypass of the row being written

    assign fwd = row_wr_en && (s2_bucket_reg == s1_bucket);

    always_ff @(posedge clk)
    begin
        if (row_wr_en)
        begin
            key_mem[s2_bucket_reg] <= wr_keys;
            val_mem[s2_bucket_reg] <= wr_vals;
        end
        if (s1_vld_reg)
        begin
            if (fwd)
            begin
                row_keys_reg <= wr_keys;
                row_vals_reg <= wr_vals;
            end
            else
            begin
                row_keys_reg <= key_mem[s1_bucket];
                row_vals_reg <= val_mem[s1_bucket];
            end
        end
    end

    // stage 3: compare, update, result

    assign valid_row = valid_reg[s2_bucket_reg];

    hkv_way_match #(
        .WAYS      (WAYS),
        .WW        (WW)
    ) u_way_match (
        .key       (s2_key_reg),
        .row_keys  (row_keys_reg),
        .row_valid (valid_row),
        .info      (way_info),
        .match_way (match_way),
        .free_way  (free_way)
    );

    always_comb
    begin
        row_wr_en      = 1'b0;
        wr_keys        = row_keys_reg;
        wr_vals        = row_vals_reg;
        valid_row_next = valid_row;
        res_value      = VAL_MISS;
        res_hit        = 1'b0;
        res_status     = ST_NOT_FOUND;
        if (s2_vld_reg)
        begin
            unique case (s2_op_reg)
                OP_INSERT:
                begin
                    if (way_info.found)
                    begin
                        row_wr_en          = 1'b1;
                        wr_vals[match_way] = s2_value_reg;
                        res_value          = VAL_ACK;
                        res_hit            = 1'b1;
                        res_status         = ST_DONE;
                    end
                    else if (way_info.have_free)
                    begin
                        row_wr_en                = 1'b1;
                        wr_keys[free_way]        = s2_key_reg;
                        wr_vals[free_way]        = s2_value_reg;
                        valid_row_next[free_way] = 1'b1;
                        res_value                = VAL_ACK;
                        res_status               = ST_DONE;
                    end
                    else
                    begin
                        res_status = ST_FULL;
                    end
                end
                OP_READ:
                begin
                    if (way_info.found)
                    begin
                        res_value  = row_vals_reg[match_way];
                        res_hit    = 1'b1;
                        res_status = ST_DONE;
                    end
                end
                OP_DELETE:
                begin
                    if (way_info.found)
                    begin
                        res_value                 = row_vals_reg[match_way];
                        res_hit                   = 1'b1;
                        res_status                = ST_DONE;
                        valid_row_next[match_way] = 1'b0;
                    end
                end
                default:
                begin
                    res_status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            valid_reg[s2_bucket_reg] <= valid_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            result_value_reg <= res_value;
            hit_reg          <= res_hit;
            status_reg       <= res_status;
        end
    end

    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign hit          = hit_reg;
    assign status       = status_reg;

`ifndef NO_ASSERTIONS
    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> (32'(s2_bucket_reg) < 32'(BUCKETS)))
        else $error("bucket index out of range");

    a_match_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && way_info.found) |-> valid_row[match_way])
        else $error("matched way is not valid");

    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && (s2_op_reg == OP_INSERT) && (res_status == ST_DONE))
        |=> (valid_reg[$past(s2_bucket_reg)] != '0))
        else $error("inserted row left with no valid way");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (!hit && (result_value == VAL_MISS)))
        else $error("bucket full word malformed");

    a_delete_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && (s2_op_reg == OP_DELETE) && way_info.found)
        |=> !valid_reg[$past(s2_bucket_reg)][$past(match_way)])
        else $error("deleted way still valid");
`endif

endmodule

// ===== test/tb_hashed_key_value_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_table_core
// Self-checking testbench for the hashed key-value table. A scoreboard
// keeps its own copy of the bucket rows, predicts the reply word of every
// accepted command and checks the words coming back on done, in order.
// Directed commands cover empty, full and reused buckets and the key and
// value extremes. Random traffic follows over a small key pool per bucket
// so that hits, misses, overwrites and full buckets are frequent.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_table_core;
    import hkv_pkg::*;

    localparam int BUCKETS      = DEFAULT_BUCKETS;
    localparam int WAYS         = DEFAULT_WAYS;
    localparam int SLOTS        = BUCKETS * WAYS;
    localparam int RANDOM_WORDS = 1950;
    localparam int IDLE_LIMIT   = 1000;
    localparam int MAX_REPORTS  = 200;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic [OP_W-1:0]           operation    = OP_READ;
    logic [KEY_W-1:0]          key          = '0;
    logic signed [VALUE_W-1:0] value        = '0;
    logic                      busy;
    logic                      done;
    logic signed [VALUE_W-1:0] result_value;
    logic                      hit;
    logic [STAT_W-1:0]         status;

    hashed_key_value_table_core #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .key          (key),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .hit          (hit),
        .status       (status)
    );

    always #5 clk = ~clk;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      hit;
        logic [STAT_W-1:0]         status;
    } reply_t;

    class kv_scoreboard;
        bit                        row_valid [SLOTS];
        logic [KEY_W-1:0]          row_key   [SLOTS];
        logic signed [VALUE_W-1:0] row_value [SLOTS];
        reply_t                    replies[$];
        int                        errors;

        function new();
            foreach (row_valid[i])
                row_valid[i] = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                   logic signed [VALUE_W-1:0] v);
            int     base;
            int     match;
            int     free_slot;
            bit     found;
            bit     have_free;
            reply_t r;
            base      = int'(k % BUCKETS) * WAYS;
            found     = 1'b0;
            have_free = 1'b0;
            match     = 0;
            free_slot = 0;
            for (int w = 0; w < WAYS; w++)
            begin
                if (row_valid[base + w])
                begin
                    if (!found && row_key[base + w] == k)
                    begin
                        found = 1'b1;
                        match = base + w;
                    end
                end
                else if (!have_free)
                begin
                    have_free = 1'b1;
                    free_slot = base + w;
                end
            end
            r = '{VAL_MISS, 1'b0, ST_NOT_FOUND};
            case (op)
                OP_INSERT:
                begin
                    if (found)
                    begin
                        row_value[match] = v;
                        r = '{VAL_ACK, 1'b1, ST_DONE};
                    end
                    else if (have_free)
                    begin
                        row_valid[free_slot] = 1'b1;
                        row_key[free_slot]   = k;
                        row_value[free_slot] = v;
                        r = '{VAL_ACK, 1'b0, ST_DONE};
                    end
                    else
                        r = '{VAL_MISS, 1'b0, ST_FULL};
                end
                OP_READ:
                begin
                    if (found)
                        r = '{row_value[match], 1'b1, ST_DONE};
                end
                OP_DELETE:
                begin
                    if (found)
                    begin
                        r = '{row_value[match], 1'b1, ST_DONE};
                        row_valid[match] = 1'b0;
                    end
                end
                default:
                    ;
            endcase
            replies.push_back(r);
        endfunction

        function void report(string field, logic [VALUE_W-1:0] expd,
                             logic [VALUE_W-1:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%08h, got 0x%08h", field, expd, got);
        endfunction

        function void check_reply(logic signed [VALUE_W-1:0] v, logic h,
                                  logic [STAT_W-1:0] s);
            reply_t exp_r;
            if (replies.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("word on done with nothing outstanding");
                return;
            end
            exp_r = replies.pop_front();
            if (v !== exp_r.value)
                report("result_value", exp_r.value, v);
            if (h !== exp_r.hit)
                report("hit", VALUE_W'(exp_r.hit), VALUE_W'(h));
            if (s !== exp_r.status)
                report("status", VALUE_W'(exp_r.status), VALUE_W'(s));
        endfunction
    endclass

    kv_scoreboard sb = new();
    longint       key_hi [8];
    int           idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply(result_value, hit, status);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // waits out the gap (and a full drain if asked), then holds start until taken
    task automatic issue_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                 logic signed [VALUE_W-1:0] v, int gap, bit drain);
        if (gap > 0 || drain)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (drain && sb.pending() > 0)
                @(posedge clk);
            repeat ((gap > 1) ? gap - 1 : 0) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        key       <= k;
        value     <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(op, k, v);
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return OP_UNUSED;
        if (r < 42)
            return OP_INSERT;
        if (r < 72)
            return OP_READ;
        return OP_DELETE;
    endfunction

    // mostly a small per-bucket key pool, often on a few hot buckets
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        int bkt;
        r = $urandom_range(0, 99);
        if (r < 12)
            return KEY_W'($urandom());
        if (r < 55)
            bkt = $urandom_range(0, 3);
        else
            bkt = $urandom_range(0, BUCKETS - 1);
        return KEY_W'(key_hi[$urandom_range(0, 7)] * BUCKETS + bkt);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'sh7FFF_FFFF;
        if (r < 10)
            return 32'sh8000_0000;
        if (r < 13)
            return '0;
        if (r < 15)
            return -32'sd1;
        return VALUE_W'($urandom());
    endfunction

    initial
    begin
        bit     burst;
        longint max_hi;
        max_hi    = (longint'(2) ** KEY_W - BUCKETS) / BUCKETS;
        key_hi[0] = 0;
        key_hi[1] = max_hi;
        for (int i = 2; i < 8; i++)
            key_hi[i] = $urandom_range(0, int'(max_hi));
        burst = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, key and value extremes
        issue_command(OP_READ,   31'd0,          32'sd0,         0, 1'b0);
        issue_command(OP_DELETE, 31'd0,          32'sd0,         0, 1'b0);
        issue_command(OP_INSERT, 31'd0,          32'sh7FFF_FFFF, 0, 1'b0);
        issue_command(OP_INSERT, 31'h7FFF_FFFF,  32'sh8000_0000, 0, 1'b0);
        issue_command(OP_READ,   31'd0,          32'sd0,         0, 1'b0);
        issue_command(OP_INSERT, 31'd0,          -32'sd1,        1, 1'b0);
        issue_command(OP_READ,   31'd0,          32'sd0,         0, 1'b0);
        issue_command(OP_READ,   31'h7FFF_FFFF,  32'sd0,         2, 1'b0);
        // fill one bucket, overflow it, free a middle way and reuse it
        issue_command(OP_INSERT, 31'd5,          32'sd11,        0, 1'b0);
        issue_command(OP_INSERT, 31'd21,         32'sd22,        0, 1'b0);
        issue_command(OP_INSERT, 31'd37,         32'sd33,        0, 1'b0);
        issue_command(OP_INSERT, 31'd53,         32'sd44,        0, 1'b0);
        issue_command(OP_INSERT, 31'd69,         32'sd55,        0, 1'b0);
        issue_command(OP_DELETE, 31'd21,         32'sd0,         0, 1'b0);
        issue_command(OP_READ,   31'd37,         32'sd0,         0, 1'b0);
        issue_command(OP_READ,   31'd21,         32'sd0,         3, 1'b0);
        issue_command(OP_INSERT, 31'd69,         32'sd55,        0, 1'b0);
        issue_command(OP_READ,   31'd69,         32'sd0,         0, 1'b0);
        issue_command(OP_INSERT, 31'h7FFF_FFF5,  32'sd66,        0, 1'b0);
        issue_command(OP_DELETE, 31'h7FFF_FFFF,  32'sd0,         0, 1'b0);
        issue_command(OP_READ,   31'h7FFF_FFFF,  32'sd0,         0, 1'b0);
        issue_command(OP_UNUSED, 31'd5,          32'sd77,        0, 1'b0);
        issue_command(OP_READ,   31'd5,          32'sd0,         5, 1'b0);
        issue_command(OP_DELETE, 31'd69,         32'sd0,         0, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            issue_command(pick_op(), pick_key(), pick_value(), pick_gap(burst),
                          (n % 400 == 0));
        end
        start <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
